>>> hdl/gdad_pkg.sv
package gdad_pkg;

    // Field widths
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int OFFSET_BITS = 16;
    // Working day count: offset plus day of month, with sign
    localparam int D_W         = OFFSET_BITS + 2;
    // Year cycle residue, 0..399
    localparam int YMOD_W      = 9;

    // Calendar constants
    localparam int MAX_YEAR    = 9999;
    localparam int YR_CYCLE    = 400;
    localparam int YR_CENTURY  = 100;
    localparam int MONTHS      = 12;
    localparam int M_JAN       = 1;
    localparam int M_FEB       = 2;
    localparam int M_APR       = 4;
    localparam int M_JUN       = 6;
    localparam int M_SEP       = 9;
    localparam int M_NOV       = 11;
    localparam int M_DEC       = 12;
    localparam int LEN_LONG    = 31;
    localparam int LEN_SHORT   = 30;
    localparam int LEN_FEB     = 28;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic done;
    } t_dp_sts;

endpackage

>>> hdl/gdad_ctrl.sv
module gdad_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  gdad_pkg::t_dp_sts i_sts,
    output gdad_pkg::t_dp_cmd o_cmd
);
    import gdad_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.done) begin
                    o_cmd.step = 1'b1;
                end else if (!r_out_valid) begin
                    // result register free: transfer result into it
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/gdad_dp.sv
module gdad_dp (
    input  logic                           i_clk,
    input  gdad_pkg::t_dp_cmd              i_cmd,
    output gdad_pkg::t_dp_sts              o_sts,
    input  logic [gdad_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [gdad_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [gdad_pkg::DAY_W-1:0]     i_start_day,
    input  logic [gdad_pkg::OFFSET_BITS-1:0] i_day_offset,
    output logic [gdad_pkg::YEAR_W-1:0]    o_new_year,
    output logic [gdad_pkg::MONTH_W-1:0]   o_new_month,
    output logic [gdad_pkg::DAY_W-1:0]     o_new_day,
    output logic                           o_out_of_range
);
    import gdad_pkg::*;

    // Year modulo 400 by six conditional subtracts
    function automatic logic [YMOD_W-1:0] f_mod400(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        r = y;
        for (int k = 5; k >= 0; k--) begin
            if (r >= YEAR_W'(YR_CYCLE << k)) begin
                r = r - YEAR_W'(YR_CYCLE << k);
            end
        end
        return r[YMOD_W-1:0];
    endfunction

    // Leap test from the 400-year residue
    function automatic logic f_leap(input logic [YMOD_W-1:0] r);
        return (r == '0) ||
               ((r[1:0] == 2'd0) && (r != YMOD_W'(YR_CENTURY)) &&
                (r != YMOD_W'(2 * YR_CENTURY)) && (r != YMOD_W'(3 * YR_CENTURY)));
    endfunction

    // Days in month
    function automatic logic [DAY_W-1:0] f_mlen(input logic [MONTH_W-1:0] m,
                                                input logic leap);
        logic [DAY_W-1:0] len;
        len = DAY_W'(LEN_LONG);
        if (m == MONTH_W'(M_FEB)) begin
            len = leap ? DAY_W'(LEN_FEB + 1) : DAY_W'(LEN_FEB);
        end else if (m == MONTH_W'(M_APR) || m == MONTH_W'(M_JUN) ||
                     m == MONTH_W'(M_SEP) || m == MONTH_W'(M_NOV)) begin
            len = DAY_W'(LEN_SHORT);
        end
        return len;
    endfunction

    // Working registers
    logic [YEAR_W-1:0]  r_y, n_y;
    logic [MONTH_W-1:0] r_m, n_m;
    logic signed [D_W-1:0] r_d, n_d;
    logic [YMOD_W-1:0]  r_ymod, n_ymod;
    logic               r_bad, n_bad;
    // Echo copy of the input date
    logic [YEAR_W-1:0]  r_y_in;
    logic [MONTH_W-1:0] r_m_in;
    logic [DAY_W-1:0]   r_d_in;
    // Result register
    logic [YEAR_W-1:0]  r_o_y;
    logic [MONTH_W-1:0] r_o_m;
    logic [DAY_W-1:0]   r_o_d;
    logic               r_o_bad;

    logic               leap;
    logic [DAY_W-1:0]   ml;
    logic [MONTH_W-1:0] m_prev;
    logic [DAY_W-1:0]   ml_prev;
    logic signed [D_W-1:0] ml_s;
    logic               fwd;
    logic               bwd;

    // Current month length and carry direction
    always_comb begin
        leap    = f_leap(r_ymod);
        ml      = f_mlen(r_m, leap);
        m_prev  = (r_m == MONTH_W'(M_JAN)) ? MONTH_W'(M_DEC) : r_m - MONTH_W'(1);
        // December is 31 days whatever the year
        ml_prev = f_mlen(m_prev, leap);
        ml_s    = $signed({{(D_W - DAY_W){1'b0}}, ml});
        fwd     = r_d > ml_s;
        bwd     = r_d <= $signed(D_W'(0));
    end

    assign o_sts.done = r_bad || (!fwd && !bwd);

    // Load and one month carry per step
    always_comb begin
        n_y    = r_y;
        n_m    = r_m;
        n_d    = r_d;
        n_ymod = r_ymod;
        n_bad  = r_bad;
        if (i_cmd.load) begin
            n_y    = i_start_year;
            n_m    = i_start_month;
            if (i_start_month == '0) begin
                n_m = MONTH_W'(M_JAN);
            end else if (i_start_month > MONTH_W'(MONTHS)) begin
                n_m = MONTH_W'(M_DEC);
            end
            n_bad  = (i_start_year == '0) || (32'(i_start_year) > MAX_YEAR);
            n_d    = $signed({{2{i_day_offset[OFFSET_BITS-1]}}, i_day_offset}) +
                     $signed({{(D_W - DAY_W){1'b0}}, i_start_day});
            n_ymod = f_mod400(i_start_year);
        end else if (i_cmd.step && !r_bad) begin
            if (fwd) begin
                n_d = r_d - ml_s;
                if (r_m == MONTH_W'(M_DEC)) begin
                    n_m = MONTH_W'(M_JAN);
                    if (32'(r_y) >= MAX_YEAR) begin
                        n_bad = 1'b1;
                    end else begin
                        n_y = r_y + YEAR_W'(1);
                    end
                    n_ymod = (r_ymod == YMOD_W'(YR_CYCLE - 1)) ? '0
                                                               : r_ymod + YMOD_W'(1);
                end else begin
                    n_m = r_m + MONTH_W'(1);
                end
            end else if (bwd) begin
                n_m = m_prev;
                n_d = r_d + $signed({{(D_W - DAY_W){1'b0}}, ml_prev});
                if (r_m == MONTH_W'(M_JAN)) begin
                    if (r_y <= YEAR_W'(1)) begin
                        n_bad = 1'b1;
                    end else begin
                        n_y = r_y - YEAR_W'(1);
                    end
                    n_ymod = (r_ymod == '0) ? YMOD_W'(YR_CYCLE - 1)
                                            : r_ymod - YMOD_W'(1);
                end
            end
        end
    end

    // Working and echo registers
    always_ff @(posedge i_clk) begin
        r_y    <= n_y;
        r_m    <= n_m;
        r_d    <= n_d;
        r_ymod <= n_ymod;
        r_bad  <= n_bad;
        if (i_cmd.load) begin
            r_y_in <= i_start_year;
            r_m_in <= i_start_month;
            r_d_in <= i_start_day;
        end
    end

    // Result register: echo input on out of range
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_bad <= r_bad;
            if (r_bad) begin
                r_o_y <= r_y_in;
                r_o_m <= r_m_in;
                r_o_d <= r_d_in;
            end else begin
                r_o_y <= r_y;
                r_o_m <= r_m;
                r_o_d <= r_d[DAY_W-1:0];
            end
        end
    end

    assign o_new_year     = r_o_y;
    assign o_new_month    = r_o_m;
    assign o_new_day      = r_o_d;
    assign o_out_of_range = r_o_bad;

endmodule

>>> hdl/gregorian_date_add_days_top.sv
// Sequential: after the input is loaded, months are carried one per cycle by the single
// carry step in the datapath; the result moves on once the output register is free.
// The next item is taken while a result waits in the output register.
// Reset: synchronous, active low; clears controller state and output valid only.
module gregorian_date_add_days_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [gdad_pkg::YEAR_W-1:0]      i_start_year,
    input  logic [gdad_pkg::MONTH_W-1:0]     i_start_month,
    input  logic [gdad_pkg::DAY_W-1:0]       i_start_day,
    input  logic [gdad_pkg::OFFSET_BITS-1:0] i_day_offset,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [gdad_pkg::YEAR_W-1:0]      o_new_year,
    output logic [gdad_pkg::MONTH_W-1:0]     o_new_month,
    output logic [gdad_pkg::DAY_W-1:0]       o_new_day,
    output logic                             o_out_of_range
);
    import gdad_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    gdad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Month carry datapath
    gdad_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_start_year   (i_start_year),
        .i_start_month  (i_start_month),
        .i_start_day    (i_start_day),
        .i_day_offset   (i_day_offset),
        .o_new_year     (o_new_year),
        .o_new_month    (o_new_month),
        .o_new_day      (o_new_day),
        .o_out_of_range (o_out_of_range)
    );

endmodule
